@@ design/pnmhp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PNM header parser package
// Shared constants, codes, the result record and byte classification helpers.
// ----------------------------------------------------------------------------
package pnmhp_pkg;

  localparam int DIM_BITS = 16;

  localparam int ACC_W = 17;
  localparam int PROD_W = ACC_W + 3;

  localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;
  localparam logic [ACC_W-1:0] DIM_LIMIT = (DIM_BITS >= 16) ? 17'd65535 :
                                           ACC_W'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [ACC_W-1:0] TWO_BYTE_MIN = 17'd256;

  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_6 = 8'h36;
  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_5 = 8'h35;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MAGIC     = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_ZERO      = 3'd4,
    ST_MAXVAL    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    MAGIC_NONE  = 3'd0,
    MAGIC_P     = 3'd1,
    MAGIC_VALID = 3'd2,
    MAGIC_BAD   = 3'd7
  } magic_t;

  typedef enum logic [1:0] {
    TOK_MAGIC  = 2'd0,
    TOK_WIDTH  = 2'd1,
    TOK_HEIGHT = 2'd2,
    TOK_MAXVAL = 2'd3
  } token_t;

  typedef struct packed {
    status_t     status;
    logic        is_color;
    logic        is_ascii;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic        two_byte_samples;
  } result_t;

  function automatic logic is_white(input logic [7:0] b);
    is_white = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= CH_0) && (b <= CH_9);
  endfunction

endpackage
`default_nettype wire

@@ design/pnm_header_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PNM header parser
// Parses the magic, width, height and maximum value tokens of a PGM or PPM
// byte stream and delivers one result transaction per header.
// ----------------------------------------------------------------------------
// Output: a result is registered into the main output entry, or into the skid entry while out_stall holds the main one.
// Throughput: one byte per cycle; the parser state is updated by a single
// decimal multiply-add per byte. A two-entry output buffer lets bytes keep
// flowing while one result waits; input stalls only while two results wait.
// Reset: synchronous, active low; the parser is rearmed and the buffer emptied.
module pnm_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_stream_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_is_color,
  output logic             out_is_ascii,
  output logic [15:0]      out_image_width,
  output logic [15:0]      out_image_height,
  output logic [15:0]      out_max_value,
  output logic             out_two_byte_samples
);
  import pnmhp_pkg::*;

  token_t             tok_r, tok_nxt;
  logic               comment_r, comment_nxt;
  logic               in_token_r, in_token_nxt;
  magic_t             magic_r, magic_nxt;
  logic               color_r, color_nxt;
  logic               ascii_r, ascii_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               malformed_r, malformed_nxt;
  logic [15:0]        width_r, width_nxt;
  logic [15:0]        height_r, height_nxt;

  result_t            main_r, main_nxt;
  logic               main_valid_r, main_valid_nxt;
  result_t            skid_r, skid_nxt;
  logic               skid_valid_r, skid_valid_nxt;

  logic               accept;
  logic               out_fire;
  logic               do_byte;
  logic               do_end;
  logic               do_trunc;
  logic               rearm;
  logic               res_valid;
  result_t            res;
  status_t            hdr_status;
  logic               dim_over;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc_step;
  magic_t             magic_step;
  logic               color_step;
  logic               ascii_step;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_fire = main_valid_r && !out_stall;

  assign prod = {3'b000, acc_r} * PROD_W'(10) + {12'b0, 8'(in_data_byte - CH_0)};
  assign acc_step = (prod > PROD_W'(ACC_SAT)) ? ACC_SAT : prod[ACC_W-1:0];
  assign dim_over = acc_r > DIM_LIMIT;

  always_comb begin
    magic_step = MAGIC_BAD;
    color_step = color_r;
    ascii_step = ascii_r;
    if (magic_r == MAGIC_NONE) begin
      magic_step = (in_data_byte == CH_P) ? MAGIC_P : MAGIC_BAD;
    end else if (magic_r == MAGIC_P) begin
      magic_step = MAGIC_VALID;
      case (in_data_byte)
        CH_6: begin
          color_step = 1'b1;
          ascii_step = 1'b0;
        end
        CH_3: begin
          color_step = 1'b1;
          ascii_step = 1'b1;
        end
        CH_5: begin
          color_step = 1'b0;
          ascii_step = 1'b0;
        end
        CH_2: begin
          color_step = 1'b0;
          ascii_step = 1'b1;
        end
        default: magic_step = MAGIC_BAD;
      endcase
    end
  end

  always_comb begin
    if (magic_r != MAGIC_VALID) begin
      hdr_status = ST_MAGIC;
    end else if (malformed_r) begin
      hdr_status = ST_MALFORMED;
    end else if (width_r == 16'd0 || height_r == 16'd0) begin
      hdr_status = ST_ZERO;
    end else if (acc_r == '0 || acc_r >= ACC_SAT) begin
      hdr_status = ST_MAXVAL;
    end else begin
      hdr_status = ST_OK;
    end
  end

  always_comb begin
    tok_nxt       = tok_r;
    comment_nxt   = comment_r;
    in_token_nxt  = in_token_r;
    magic_nxt     = magic_r;
    color_nxt     = color_r;
    ascii_nxt     = ascii_r;
    acc_nxt       = acc_r;
    malformed_nxt = malformed_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    do_byte       = 1'b0;
    do_end        = 1'b0;
    do_trunc      = 1'b0;
    rearm         = 1'b0;
    res_valid     = 1'b0;
    res           = '0;

    if (accept) begin
      if (in_stream_end) begin
        if (in_token_r && tok_r == TOK_MAXVAL) begin
          do_end = 1'b1;
        end else begin
          do_trunc = 1'b1;
        end
      end else if (comment_r) begin
        if (in_data_byte == CH_LF) begin
          comment_nxt = 1'b0;
        end
      end else if (in_token_r) begin
        if (is_white(in_data_byte)) begin
          do_end = 1'b1;
        end else begin
          do_byte = 1'b1;
        end
      end else if (!is_white(in_data_byte)) begin
        if (in_data_byte == CH_HASH) begin
          comment_nxt = 1'b1;
        end else begin
          in_token_nxt = 1'b1;
          do_byte = 1'b1;
        end
      end
    end

    if (do_byte) begin
      if (tok_r == TOK_MAGIC) begin
        magic_nxt = magic_step;
        color_nxt = color_step;
        ascii_nxt = ascii_step;
      end else if (is_digit(in_data_byte)) begin
        acc_nxt = acc_step;
      end else begin
        malformed_nxt = 1'b1;
      end
    end

    if (do_end) begin
      in_token_nxt = 1'b0;
      acc_nxt = '0;
      case (tok_r)
        TOK_MAGIC: begin
          if (magic_r != MAGIC_VALID) begin
            magic_nxt = MAGIC_BAD;
          end
          tok_nxt = TOK_WIDTH;
        end
        TOK_WIDTH: begin
          width_nxt = dim_over ? 16'd0 : acc_r[15:0];
          if (dim_over) begin
            malformed_nxt = 1'b1;
          end
          tok_nxt = TOK_HEIGHT;
        end
        TOK_HEIGHT: begin
          height_nxt = dim_over ? 16'd0 : acc_r[15:0];
          if (dim_over) begin
            malformed_nxt = 1'b1;
          end
          tok_nxt = TOK_MAXVAL;
        end
        default: begin
          res_valid = 1'b1;
          res.status = hdr_status;
          if (hdr_status == ST_OK) begin
            res.is_color = color_r;
            res.is_ascii = ascii_r;
            res.image_width = width_r;
            res.image_height = height_r;
            res.max_value = acc_r[15:0];
            res.two_byte_samples = acc_r >= TWO_BYTE_MIN;
          end
          rearm = 1'b1;
        end
      endcase
    end

    if (do_trunc) begin
      res_valid = 1'b1;
      res.status = ST_TRUNC;
      rearm = 1'b1;
    end

    if (rearm) begin
      tok_nxt       = TOK_MAGIC;
      comment_nxt   = 1'b0;
      in_token_nxt  = 1'b0;
      magic_nxt     = MAGIC_NONE;
      color_nxt     = 1'b0;
      ascii_nxt     = 1'b0;
      acc_nxt       = '0;
      malformed_nxt = 1'b0;
      width_nxt     = 16'd0;
      height_nxt    = 16'd0;
    end
  end

  // A new result can only arrive while the skid entry is empty.
  always_comb begin
    main_nxt       = main_r;
    main_valid_nxt = main_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!main_valid_r || out_fire) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = res;
        main_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r        <= TOK_MAGIC;
      comment_r    <= 1'b0;
      in_token_r   <= 1'b0;
      magic_r      <= MAGIC_NONE;
      color_r      <= 1'b0;
      ascii_r      <= 1'b0;
      acc_r        <= '0;
      malformed_r  <= 1'b0;
      width_r      <= 16'd0;
      height_r     <= 16'd0;
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      tok_r        <= tok_nxt;
      comment_r    <= comment_nxt;
      in_token_r   <= in_token_nxt;
      magic_r      <= magic_nxt;
      color_r      <= color_nxt;
      ascii_r      <= ascii_nxt;
      acc_r        <= acc_nxt;
      malformed_r  <= malformed_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid            = main_valid_r;
  assign out_status           = main_r.status;
  assign out_is_color         = main_r.is_color;
  assign out_is_ascii         = main_r.is_ascii;
  assign out_image_width      = main_r.image_width;
  assign out_image_height     = main_r.image_height;
  assign out_max_value        = main_r.max_value;
  assign out_two_byte_samples = main_r.two_byte_samples;

endmodule
`default_nettype wire
